// ----- rtl/hrme_pkg.sv -----
// Shared types, constants and helper functions for the Hubbard ring matrix element block.
// Depends on nothing; every other file of the block imports it.
package hrme_pkg;

   // Ring and mask geometry.
   localparam int MAX_SITES = 32;
   localparam int MASK_W    = 32;
   localparam int IDX_W     = $clog2(MAX_SITES);
   localparam int CNT_W     = $clog2(MAX_SITES + 1);
   localparam int MIN_SITES = 2;

   // Register file geometry.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SITE_W     = 6;
   localparam int COEF_W     = 16;

   // Arithmetic widths of the result path.
   localparam int HOP_CNT_W  = 3;
   localparam int HOP_PROD_W = COEF_W + HOP_CNT_W;
   localparam int INT_PROD_W = 22;
   localparam int ELEM_W     = 22;
   localparam int SUM_W      = ELEM_W + 1;

   // Saturation bounds of the element value.
   localparam logic signed [SUM_W-1:0] ELEM_MIN = -SUM_W'(1048576);
   localparam logic signed [SUM_W-1:0] ELEM_MAX = SUM_W'(1048576);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SITE_COUNT     = 3'd0,
      REG_UP_PARTICLES   = 3'd1,
      REG_DOWN_PARTICLES = 3'd2,
      REG_HOP_STRENGTH   = 3'd3,
      REG_INTERACTION    = 3'd4
   } csr_index_type;

   // Decoded configuration as seen by the datapath.
   typedef struct packed {
      logic [IDX_W-1:0]  last_site;
      logic [MASK_W-1:0] ring_mask;
      logic              up_odd;
      logic              down_odd;
      logic [COEF_W-1:0] hop_strength;
      logic [COEF_W-1:0] interaction;
   } cfg_type;

   // Hop detection flags of one spin species.
   typedef struct packed {
      logic pop2;
      logic inner_hit;
      logic seam_hit;
   } hop_flags_type;

   // Stage 1 payload: masked row masks and row/column differences.
   typedef struct packed {
      logic [MASK_W-1:0] ru;
      logic [MASK_W-1:0] rd;
      logic [MASK_W-1:0] du;
      logic [MASK_W-1:0] dd;
   } s1_type;

   // Stage 2 payload: hop flags, equality flags and double occupancy.
   typedef struct packed {
      hop_flags_type    up_hop;
      hop_flags_type    dn_hop;
      logic             up_eq;
      logic             dn_eq;
      logic [CNT_W-1:0] dbl;
   } s2_type;

   // Stage 3 payload: the two partial products.
   typedef struct packed {
      logic [HOP_PROD_W-1:0] hop_prod;
      logic [INT_PROD_W-1:0] int_prod;
      logic [CNT_W-1:0]      dbl;
   } s3_type;

   // Number of set bits in a mask.
   function automatic logic [CNT_W-1:0] count_ones(input logic [MASK_W-1:0] v);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < MASK_W; i++) begin
         c = c + CNT_W'(v[i]);
      end
      return c;
   endfunction

endpackage

// ----- rtl/hrme_if.sv -----
// Channel interfaces of the Hubbard ring matrix element block: request, response, register write.
// Depends on hrme_pkg for field widths.

// Request channel: one row/column basis state pair per transfer.
interface hrme_req_if
   import hrme_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] row_up;
   logic [MASK_W-1:0] row_down;
   logic [MASK_W-1:0] col_up;
   logic [MASK_W-1:0] col_down;

   modport source(output valid, row_up, row_down, col_up, col_down, input ready);
   modport sink(input valid, row_up, row_down, col_up, col_down, output ready);
endinterface

// Response channel: one matrix element per transfer.
interface hrme_rsp_if
   import hrme_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] element_value;
   logic [CNT_W-1:0]         double_occupied;

   modport source(output valid, element_value, double_occupied, input ready);
   modport sink(input valid, element_value, double_occupied, output ready);
endinterface

// Register write channel.
interface hrme_csr_if
   import hrme_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/hrme_csr.sv -----
// Configuration registers of the Hubbard ring matrix element block and their decoding.
// Depends on hrme_pkg and the hrme_csr_if interface.
module hrme_csr
   import hrme_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   hrme_csr_if.sink     csr_ch,
   output cfg_type      cfg
);

   logic [SITE_W-1:0] site_count_ff, site_count_in;
   logic [SITE_W-1:0] up_part_ff, up_part_in;
   logic [SITE_W-1:0] down_part_ff, down_part_in;
   logic [COEF_W-1:0] hop_ff, hop_in;
   logic [COEF_W-1:0] inter_ff, inter_in;
   logic [SITE_W-1:0] sites_clamped;

   // Writes are always taken.
   assign csr_ch.ready = 1'b1;

   // Register write decode; unknown indexes are dropped.
   always_comb begin
      site_count_in = site_count_ff;
      up_part_in    = up_part_ff;
      down_part_in  = down_part_ff;
      hop_in        = hop_ff;
      inter_in      = inter_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_SITE_COUNT:     site_count_in = csr_ch.data[SITE_W-1:0];
            REG_UP_PARTICLES:   up_part_in    = csr_ch.data[SITE_W-1:0];
            REG_DOWN_PARTICLES: down_part_in  = csr_ch.data[SITE_W-1:0];
            REG_HOP_STRENGTH:   hop_in        = csr_ch.data[COEF_W-1:0];
            REG_INTERACTION:    inter_in      = csr_ch.data[COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_count_ff <= SITE_W'(4);
         up_part_ff    <= SITE_W'(2);
         down_part_ff  <= SITE_W'(3);
         hop_ff        <= COEF_W'(256);
         inter_ff      <= '0;
      end else begin
         site_count_ff <= site_count_in;
         up_part_ff    <= up_part_in;
         down_part_ff  <= down_part_in;
         hop_ff        <= hop_in;
         inter_ff      <= inter_in;
      end
   end

   // Clamp the ring size into the supported range.
   always_comb begin
      if (site_count_ff < SITE_W'(MIN_SITES)) begin
         sites_clamped = SITE_W'(MIN_SITES);
      end else if (site_count_ff > SITE_W'(MAX_SITES)) begin
         sites_clamped = SITE_W'(MAX_SITES);
      end else begin
         sites_clamped = site_count_ff;
      end
   end

   // Decoded view for the datapath: last site index and the in-use mask.
   always_comb begin
      cfg.last_site = IDX_W'(sites_clamped - SITE_W'(1));
      for (int i = 0; i < MASK_W; i++) begin
         cfg.ring_mask[i] = (SITE_W'(i) < sites_clamped);
      end
      cfg.up_odd       = up_part_ff[0];
      cfg.down_odd     = down_part_ff[0];
      cfg.hop_strength = hop_ff;
      cfg.interaction  = inter_ff;
   end

endmodule

// ----- rtl/hrme_hop.sv -----
// Single-hop detector for one spin species on the ring.
// Depends on hrme_pkg for the mask width and the flag struct.
module hrme_hop
   import hrme_pkg::*;
(
   input  logic [MASK_W-1:0] occ,
   input  logic [MASK_W-1:0] diff,
   input  logic [IDX_W-1:0]  last_site,
   output hop_flags_type     flags
);

   logic [MASK_W-2:0] inner_pairs;

   // The states differ by a single hop only when exactly two sites flip.
   assign flags.pop2 = (count_ones(diff) == CNT_W'(2));

   // Neighbor pairs inside the ring that both flip with exactly one of them occupied.
   // Bits above the ring are zero in both masks, so pairs beyond it never fire.
   assign inner_pairs = diff[MASK_W-2:0] & diff[MASK_W-1:1]
                      & (occ[MASK_W-2:0] ^ occ[MASK_W-1:1]);
   assign flags.inner_hit = |inner_pairs;

   // The pair across the seam between the last site and site zero.
   assign flags.seam_hit = diff[last_site] & diff[0] & (occ[last_site] ^ occ[0]);

endmodule

// ----- rtl/hubbard_ring_matrix_element.sv -----
// Hubbard ring matrix element: takes one row/column basis state pair per cycle on req_ch and
// returns the Q14.8 Hamiltonian element with the row's double occupancy on rsp_ch. The datapath
// is a four-register pipeline (masking, hop detection and counting, multiplication, sum and
// saturation into the output register). Each result passes through the stage 1, 2 and 3 registers
// and the output register before it is presented on rsp_ch. The sustained rate is one pair per
// cycle while rsp_ch keeps taking results.
// Back-pressure from rsp_ch stalls the stages in place and nothing is dropped or repeated.
// Configuration registers on csr_ch are always taken and are meant to be written while
// no item is in flight.
module hubbard_ring_matrix_element
   import hrme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   hrme_req_if.sink   req_ch,
   hrme_rsp_if.source rsp_ch,
   hrme_csr_if.sink   csr_ch
);

   cfg_type cfg;

   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic go1, go2, go3, go_out;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;

   logic signed [ELEM_W-1:0] elem_ff, elem_in;
   logic [CNT_W-1:0]         dbl_ff, dbl_in;

   hop_flags_type up_flags, dn_flags;

   logic signed [HOP_CNT_W-1:0]  up_cnt, dn_cnt, hop_cnt;
   logic signed [HOP_PROD_W-1:0] j_ext, h_ext;
   logic signed [INT_PROD_W-1:0] u_ext, d_ext;
   logic signed [SUM_W-1:0]      sum;

   // Register file.
   hrme_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // Stage advance: a stage moves when it is empty or the one after it moves.
   assign go_out       = !out_v_ff || rsp_ch.ready;
   assign go3          = !s3_v_ff || go_out;
   assign go2          = !s2_v_ff || go3;
   assign go1          = !s1_v_ff || go2;
   assign req_ch.ready = go1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (go1) begin
            s1_v_ff <= req_ch.valid;
         end
         if (go2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (go3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (go_out) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   // Stage 1: drop bits above the ring and form the row/column differences.
   always_comb begin
      s1_in.ru = req_ch.row_up & cfg.ring_mask;
      s1_in.rd = req_ch.row_down & cfg.ring_mask;
      s1_in.du = (req_ch.row_up ^ req_ch.col_up) & cfg.ring_mask;
      s1_in.dd = (req_ch.row_down ^ req_ch.col_down) & cfg.ring_mask;
   end

   // Stage 2: single-hop detection per spin, equality flags and double occupancy.
   hrme_hop u_hop_up (
      .occ       (s1_ff.ru),
      .diff      (s1_ff.du),
      .last_site (cfg.last_site),
      .flags     (up_flags)
   );

   hrme_hop u_hop_dn (
      .occ       (s1_ff.rd),
      .diff      (s1_ff.dd),
      .last_site (cfg.last_site),
      .flags     (dn_flags)
   );

   always_comb begin
      s2_in.up_hop = up_flags;
      s2_in.dn_hop = dn_flags;
      s2_in.up_eq  = (s1_ff.du == '0);
      s2_in.dn_eq  = (s1_ff.dd == '0);
      s2_in.dbl    = count_ones(s1_ff.ru & s1_ff.rd);
   end

   // Stage 3: signed hop count, then the hopping and interaction products.
   // An inner hop counts -1; a seam hop counts -1 for an odd count and +1 for an even one.
   always_comb begin
      up_cnt = '0;
      if (s2_ff.up_hop.pop2 && s2_ff.dn_eq) begin
         if (s2_ff.up_hop.inner_hit) begin
            up_cnt = up_cnt - HOP_CNT_W'(1);
         end
         if (s2_ff.up_hop.seam_hit) begin
            up_cnt = cfg.up_odd ? up_cnt - HOP_CNT_W'(1) : up_cnt + HOP_CNT_W'(1);
         end
      end
      dn_cnt = '0;
      if (s2_ff.dn_hop.pop2 && s2_ff.up_eq) begin
         if (s2_ff.dn_hop.inner_hit) begin
            dn_cnt = dn_cnt - HOP_CNT_W'(1);
         end
         if (s2_ff.dn_hop.seam_hit) begin
            dn_cnt = cfg.down_odd ? dn_cnt - HOP_CNT_W'(1) : dn_cnt + HOP_CNT_W'(1);
         end
      end
      hop_cnt = up_cnt + dn_cnt;
   end

   assign j_ext = HOP_PROD_W'($signed(cfg.hop_strength));
   assign h_ext = HOP_PROD_W'(hop_cnt);
   assign u_ext = INT_PROD_W'($signed(cfg.interaction));
   assign d_ext = INT_PROD_W'($signed({1'b0, s2_ff.dbl}));

   always_comb begin
      s3_in.hop_prod = j_ext * h_ext;
      s3_in.int_prod = (s2_ff.up_eq && s2_ff.dn_eq) ? u_ext * d_ext : '0;
      s3_in.dbl      = s2_ff.dbl;
   end

   // Stage 4: add the products and saturate into the output register.
   assign sum = SUM_W'($signed(s3_ff.hop_prod)) + SUM_W'($signed(s3_ff.int_prod));

   always_comb begin
      if (sum < ELEM_MIN) begin
         elem_in = ELEM_W'(ELEM_MIN);
      end else if (sum > ELEM_MAX) begin
         elem_in = ELEM_W'(ELEM_MAX);
      end else begin
         elem_in = ELEM_W'(sum);
      end
      dbl_in = s3_ff.dbl;
   end

   // Payload registers move with their valid bits.
   always_ff @(posedge clock) begin
      if (go1) begin
         s1_ff <= s1_in;
      end
      if (go2) begin
         s2_ff <= s2_in;
      end
      if (go3) begin
         s3_ff <= s3_in;
      end
      if (go_out) begin
         elem_ff <= elem_in;
         dbl_ff  <= dbl_in;
      end
   end

   assign rsp_ch.valid           = out_v_ff;
   assign rsp_ch.element_value   = elem_ff;
   assign rsp_ch.double_occupied = dbl_ff;

   // A request transfer always lands in stage 1.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> s1_v_ff)
      else $error("request transfer did not enter stage 1");

   // Requests are held off only when every stage holds an item.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (s1_v_ff && s2_v_ff && s3_v_ff && out_v_ff))
      else $error("request stalled with an empty pipeline stage");

   // A presented element is always inside the saturation range.
   a_elem_range: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (SUM_W'(elem_ff) >= ELEM_MIN && SUM_W'(elem_ff) <= ELEM_MAX))
      else $error("element value outside saturation range");

endmodule
